// ----- rtl/dlvbi_pkg.sv -----
// Shared types and constants for the display list vertex byte inserter.
package dlvbi_pkg;

  // Output alignment: padding brings the output length to a multiple of this.
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ALIGN_BYTES = 1 << CNT_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_STRIDE = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_BASE   = 3'd2;
  localparam logic [2:0] REG_FAN    = 3'd3;
  localparam logic [2:0] REG_STRIP  = 3'd4;

  typedef struct packed {
    logic [7:0] vertex_stride;
    logic [7:0] insert_offset;
    logic [7:0] index_base;
    logic [7:0] fan_opcode;
    logic [7:0] strip_opcode;
  } cfg_t;

  // Output work produced by one input byte. Mask bit 0 is an inserted byte
  // before the data byte, bit 1 the data byte, bit 2 an inserted byte after it.
  typedef struct packed {
    logic [7:0]       ins;
    logic [7:0]       data;
    logic [2:0]       mask;
    logic [CNT_W-1:0] pad;
    logic             fin;
    logic             ended;
  } plan_t;

endpackage

// ----- rtl/dlvbi_parse.sv -----
// Display list parser: tracks command, count and vertex position per input byte.
module dlvbi_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  dlvbi_pkg::cfg_t     cfg,
  input  logic                take,
  input  logic [7:0]          item_byte,
  input  logic                item_last,
  output dlvbi_pkg::plan_t    plan
);

  localparam logic [1:0] PH_CMD    = 2'd0;
  localparam logic [1:0] PH_CNT_HI = 2'd1;
  localparam logic [1:0] PH_CNT_LO = 2'd2;
  localparam logic [1:0] PH_VTX    = 2'd3;

  logic [1:0]                  phase_r, phase_nxt;
  logic [7:0]                  cnt_hi_r, cnt_hi_nxt;
  logic [15:0]                 left_r, left_nxt;
  logic [7:0]                  biv_r, biv_nxt;
  logic [7:0]                  first_r, first_nxt;
  logic [dlvbi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                        stop_r, stop_nxt;

  logic [8:0]                  stride;
  logic [8:0]                  off;
  logic [8:0]                  k_inc;
  logic [7:0]                  fvb;
  logic [dlvbi_pkg::CNT_W-1:0] ndata;
  logic [dlvbi_pkg::CNT_W-1:0] cnt_after;
  logic                        restart;

  always_comb begin
    stride = (cfg.vertex_stride == 8'd0) ? 9'd256 : {1'b0, cfg.vertex_stride};
    off    = ({1'b0, cfg.insert_offset} > stride) ? stride : {1'b0, cfg.insert_offset};
    k_inc  = {1'b0, biv_r} + 9'd1;
    fvb    = (biv_r == 8'd0) ? item_byte : first_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_hi_nxt = cnt_hi_r;
    left_nxt   = left_r;
    biv_nxt    = biv_r;
    first_nxt  = first_r;
    stop_nxt   = stop_r;
    restart    = 1'b0;
    plan       = '0;
    plan.data  = item_byte;
    plan.ins   = cfg.index_base + fvb;

    if (stop_r) begin
      restart = item_last;
    end else begin
      unique case (phase_r)
        PH_CMD: begin
          plan.mask[1] = 1'b1;
          if (item_byte == cfg.fan_opcode || item_byte == cfg.strip_opcode) begin
            phase_nxt = PH_CNT_HI;
          end else begin
            plan.fin   = 1'b1;
            plan.ended = 1'b1;
            stop_nxt   = 1'b1;
          end
        end
        PH_CNT_HI: begin
          plan.mask[1] = 1'b1;
          cnt_hi_nxt   = item_byte;
          phase_nxt    = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          plan.mask[1] = 1'b1;
          left_nxt     = {cnt_hi_r, item_byte};
          biv_nxt      = 8'd0;
          phase_nxt    = ({cnt_hi_r, item_byte} == 16'd0) ? PH_CMD : PH_VTX;
        end
        PH_VTX: begin
          first_nxt    = fvb;
          plan.mask[0] = ({1'b0, biv_r} == off);
          plan.mask[1] = 1'b1;
          if (k_inc >= stride) begin
            plan.mask[2] = (off == stride);
            biv_nxt      = 8'd0;
            left_nxt     = left_r - 16'd1;
            if (left_r == 16'd1) begin
              phase_nxt = PH_CMD;
            end
          end else begin
            biv_nxt = k_inc[7:0];
          end
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
      if (item_last) begin
        plan.fin = 1'b1;
        restart  = 1'b1;
      end
    end

    ndata = {{(dlvbi_pkg::CNT_W-1){1'b0}}, plan.mask[0]}
          + {{(dlvbi_pkg::CNT_W-1){1'b0}}, plan.mask[1]}
          + {{(dlvbi_pkg::CNT_W-1){1'b0}}, plan.mask[2]};
    cnt_after = cnt_r + ndata;
    cnt_nxt   = cnt_after;
    if (plan.fin) begin
      // Zeros needed to reach the next alignment boundary.
      plan.pad = '0 - cnt_after;
      cnt_nxt  = '0;
    end

    if (restart) begin
      phase_nxt  = PH_CMD;
      cnt_hi_nxt = 8'd0;
      left_nxt   = 16'd0;
      biv_nxt    = 8'd0;
      first_nxt  = 8'd0;
      cnt_nxt    = '0;
      stop_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      cnt_hi_r <= 8'd0;
      left_r   <= 16'd0;
      biv_r    <= 8'd0;
      first_r  <= 8'd0;
      cnt_r    <= '0;
      stop_r   <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      cnt_hi_r <= cnt_hi_nxt;
      left_r   <= left_nxt;
      biv_r    <= biv_nxt;
      first_r  <= first_nxt;
      cnt_r    <= cnt_nxt;
      stop_r   <= stop_nxt;
    end
  end

  a_vtx_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VTX |-> left_r != 16'd0)
    else $error("vertex phase with zero vertices left");
  a_stop_only_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> phase_r == PH_CMD)
    else $error("stopped while inside a draw command");
  a_biv_in_stride: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VTX |-> {1'b0, biv_r} < stride)
    else $error("vertex byte position beyond stride");

endmodule

// ----- rtl/dlvbi_emit.sv -----
// Output sequencer: moves one plan byte per unstalled cycle into the output register.
module dlvbi_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  dlvbi_pkg::plan_t plan_in,
  input  logic             plan_valid,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_ended_early
);

  dlvbi_pkg::plan_t            plan_r, plan_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic                        out_ended_r;

  logic                        busy;
  logic                        out_free;
  logic                        pop;
  logic                        last_pop;
  logic                        plan_load;
  logic [7:0]                  pop_byte;
  logic [2:0]                  mask_after;
  logic [dlvbi_pkg::CNT_W-1:0] pad_after;

  always_comb begin
    busy     = (plan_r.mask != 3'b000) || (plan_r.pad != '0);
    out_free = !out_valid_r || !out_stall;
    pop      = busy && out_free;

    mask_after = plan_r.mask;
    pad_after  = plan_r.pad;
    pop_byte   = 8'd0;
    if (plan_r.mask[0]) begin
      pop_byte      = plan_r.ins;
      mask_after[0] = 1'b0;
    end else if (plan_r.mask[1]) begin
      pop_byte      = plan_r.data;
      mask_after[1] = 1'b0;
    end else if (plan_r.mask[2]) begin
      pop_byte      = plan_r.ins;
      mask_after[2] = 1'b0;
    end else if (plan_r.pad != '0) begin
      pad_after = plan_r.pad - {{(dlvbi_pkg::CNT_W-1){1'b0}}, 1'b1};
    end
    last_pop  = busy && (mask_after == 3'b000) && (pad_after == '0);
    load_ok   = !busy || (pop && last_pop);
    plan_load = load_ok && plan_valid;

    plan_nxt = plan_r;
    if (plan_load) begin
      plan_nxt = plan_in;
    end else if (pop) begin
      plan_nxt.mask = mask_after;
      plan_nxt.pad  = pad_after;
    end

    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    plan_r.ins   <= plan_nxt.ins;
    plan_r.data  <= plan_nxt.data;
    plan_r.fin   <= plan_nxt.fin;
    plan_r.ended <= plan_nxt.ended;
    if (!rst_n) begin
      plan_r.mask <= 3'b000;
      plan_r.pad  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      plan_r.mask <= plan_nxt.mask;
      plan_r.pad  <= plan_nxt.pad;
      out_valid_r <= out_valid_nxt;
    end
    if (pop) begin
      out_byte_r  <= pop_byte;
      out_last_r  <= plan_r.fin && last_pop;
      out_ended_r <= plan_r.ended;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_ended_early = out_ended_r;

  a_pad_needs_fin: assert property (@(posedge clk) disable iff (!rst_n)
    plan_r.pad != '0 |-> plan_r.fin)
    else $error("padding pending without a finishing plan");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    plan_load |-> !busy || last_pop)
    else $error("plan overwritten while bytes remain");
  a_hold_plan: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !out_free |=> $stable(plan_r.mask) && $stable(plan_r.pad))
    else $error("plan advanced while the output was stalled");

endmodule

// ----- rtl/display_list_vertex_byte_inserter_top.sv -----
// Top level of the display list vertex byte inserter.
// The block takes one display list byte per cycle while in_stall is low and
// returns the rewritten list one byte per cycle while out_stall is low; each
// output byte is a transaction of its own. An accepted input byte is held in
// the input register, where the parser decides what it emits, then in the
// sequencer's plan register, from which each byte moves into the output
// register. Most input bytes emit exactly one byte, so with the output not
// stalled input and output run at one transaction per cycle. A vertex byte at
// the insertion point emits two, and the final byte of a list or a stopping
// command adds up to 31 zero padding bytes; while the extra bytes play out the
// input is stalled. The single output byte per cycle is what bounds
// throughput. Configuration writes are always ready and must be made
// only while the block holds no unfinished list byte.
module display_list_vertex_byte_inserter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_ended_early,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  dlvbi_pkg::cfg_t  cfg_r;
  dlvbi_pkg::plan_t plan;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       load_ok;
  logic       take;
  logic       in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertex_stride <= 8'd1;
      cfg_r.insert_offset <= 8'd0;
      cfg_r.index_base    <= 8'd0;
      cfg_r.fan_opcode    <= 8'd160;
      cfg_r.strip_opcode  <= 8'd152;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dlvbi_pkg::REG_STRIDE: cfg_r.vertex_stride <= cfg_data;
        dlvbi_pkg::REG_OFFSET: cfg_r.insert_offset <= cfg_data;
        dlvbi_pkg::REG_BASE:   cfg_r.index_base    <= cfg_data;
        dlvbi_pkg::REG_FAN:    cfg_r.fan_opcode    <= cfg_data;
        dlvbi_pkg::REG_STRIP:  cfg_r.strip_opcode  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The held byte is consumed as soon as the sequencer can take its plan.
  assign take      = in_v_r && load_ok;
  assign in_stall  = in_v_r && !load_ok;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_accept || (in_v_r && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  dlvbi_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .take      (take),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .plan      (plan)
  );

  dlvbi_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .plan_in         (plan),
    .plan_valid      (in_v_r),
    .load_ok         (load_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_ended_early (out_ended_early)
  );

endmodule

// ----- test/tb_display_list_vertex_byte_inserter_top.sv -----
// Self-checking testbench for the display list vertex byte inserter top level.
module tb_display_list_vertex_byte_inserter_top;

  typedef enum logic [1:0] {WANT_CMD, WANT_CNT_HI, WANT_CNT_LO, IN_VERTEX} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } list_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       ended;
  } rewritten_byte_t;

  typedef logic [7:0] byte_q_t[$];

  // Predicts the rewritten list and checks the output bytes against it.
  class dl_rewrite_scoreboard;
    logic [7:0]      stride_r, offset_r, base_r, fan_r, strip_r;
    parse_phase_t    phase;
    logic [7:0]      count_hi;
    logic [15:0]     verts_left;
    logic [7:0]      vbyte_idx;
    logic [7:0]      first_b;
    logic [4:0]      out_cnt;
    bit              stopped;
    rewritten_byte_t step_q[$];
    rewritten_byte_t pending_q[$];
    int unsigned     errors;
    int unsigned     matched;

    function new();
      stride_r = 8'd1;
      offset_r = 8'd0;
      base_r   = 8'd0;
      fan_r    = 8'd160;
      strip_r  = 8'd152;
      errors   = 0;
      matched  = 0;
      restart();
    endfunction

    function void restart();
      phase      = WANT_CMD;
      count_hi   = '0;
      verts_left = '0;
      vbyte_idx  = '0;
      first_b    = '0;
      out_cnt    = '0;
      stopped    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        dlvbi_pkg::REG_STRIDE: stride_r = val;
        dlvbi_pkg::REG_OFFSET: offset_r = val;
        dlvbi_pkg::REG_BASE:   base_r   = val;
        dlvbi_pkg::REG_FAN:    fan_r    = val;
        dlvbi_pkg::REG_STRIP:  strip_r  = val;
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] v);
      step_q.push_back('{v, 1'b0, 1'b0});
      out_cnt++;
    endfunction

    // Zero pad to the alignment boundary and mark the final byte.
    function void pad_out();
      while (out_cnt != 0) emit(8'h00);
      if (step_q.size() > 0) step_q[step_q.size()-1].is_last = 1'b1;
    endfunction

    function void flush();
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
      step_q.delete();
    endfunction

    function void note_input(logic [7:0] b, logic is_last);
      int unsigned stride_eff, off, k;
      logic [7:0]  ins;
      step_q.delete();
      if (stopped) begin
        if (is_last) restart();
        return;
      end
      case (phase)
        WANT_CMD: begin
          emit(b);
          if (b == fan_r || b == strip_r) begin
            phase = WANT_CNT_HI;
          end else begin
            // A non-draw command closes the output list right away.
            pad_out();
            foreach (step_q[i]) step_q[i].ended = 1'b1;
            if (is_last) restart();
            else stopped = 1;
            flush();
            return;
          end
        end
        WANT_CNT_HI: begin
          emit(b);
          count_hi = b;
          phase    = WANT_CNT_LO;
        end
        WANT_CNT_LO: begin
          emit(b);
          verts_left = {count_hi, b};
          vbyte_idx  = '0;
          phase      = (verts_left == 0) ? WANT_CMD : IN_VERTEX;
        end
        default: begin
          stride_eff = (stride_r == 0) ? 256 : stride_r;
          off        = (offset_r > stride_eff) ? stride_eff : offset_r;
          k          = vbyte_idx;
          if (k == 0) first_b = b;
          ins = base_r + first_b;
          if (k == off) emit(ins);
          emit(b);
          if (k + 1 >= stride_eff) begin
            if (off == stride_eff) emit(ins);
            vbyte_idx  = '0;
            verts_left = verts_left - 16'd1;
            if (verts_left == 0) phase = WANT_CMD;
          end else begin
            vbyte_idx = 8'(k + 1);
          end
        end
      endcase
      if (is_last) begin
        pad_out();
        restart();
      end
      flush();
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic is_last, logic ended);
      rewritten_byte_t exp_b;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected output byte %02h last=%b ended=%b", data, is_last, ended));
      end else begin
        exp_b = pending_q.pop_front();
        if (data !== exp_b.data)
          report($sformatf("out_byte %02h, want %02h", data, exp_b.data));
        else if (is_last !== exp_b.is_last)
          report($sformatf("out_last %b, want %b (byte %02h)", is_last, exp_b.is_last, data));
        else if (ended !== exp_b.ended)
          report($sformatf("out_ended_early %b, want %b (byte %02h)", ended, exp_b.ended, data));
        else
          matched++;
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_ended_early;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = dlvbi_pkg::REG_STRIDE;
  logic [7:0] cfg_data = 8'h00;

  dl_rewrite_scoreboard sb;
  list_byte_t  list_q[$];
  int unsigned list_junk;
  int unsigned bytes_sent;
  int unsigned lists_sent;
  int unsigned settings_used;
  bit          no_gaps = 0;

  display_list_vertex_byte_inserter_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_ended_early (out_ended_early),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 23);
  end

  // Handshakes are sampled mid-cycle, when every driven value has settled.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_byte, out_last, out_ended_early);
  end

  function automatic void add_byte(logic [7:0] b);
    list_q.push_back('{b, 1'b0});
  endfunction

  // Builds one random list: mostly draw commands with random vertex data,
  // sometimes a stopping command, a truncated list or plain noise.
  function automatic void gen_list();
    int unsigned stride_eff, nb, pick, keep;
    logic [15:0] cnt;
    logic [7:0]  op;
    bit          cut;
    list_q.delete();
    cut        = 0;
    list_junk  = 0;
    stride_eff = (sb.stride_r == 0) ? 256 : sb.stride_r;
    pick       = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3, 1)) begin
        if (!cut) begin
          op = $urandom_range(1) ? sb.fan_r : sb.strip_r;
          if ($urandom_range(99) < 8) cnt = 16'($urandom_range(65535));
          else cnt = 16'($urandom_range(stride_eff > 16 ? 1 : 4));
          add_byte(op);
          add_byte(cnt[15:8]);
          add_byte(cnt[7:0]);
          nb = cnt * stride_eff;
          if (nb > 4 * stride_eff) begin
            nb  = $urandom_range(2 * stride_eff);
            cut = 1;
          end
          repeat (nb) add_byte(8'($urandom_range(255)));
        end
      end
      if (!cut && pick < 30) begin
        do op = 8'($urandom_range(255)); while (op == sb.fan_r || op == sb.strip_r);
        add_byte(op);
        list_junk = $urandom_range(3);
        repeat (list_junk) add_byte(8'($urandom_range(255)));
      end else if (!cut && pick < 45) begin
        keep = $urandom_range(list_q.size(), 1);
        while (list_q.size() > keep) void'(list_q.pop_back());
      end
    end
    list_q[list_q.size()-1].is_last = 1'b1;
  endfunction

  task automatic send_byte(list_byte_t item);
    bit acc;
    while (!no_gaps && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= item.data;
    in_last  <= item.is_last;
    do begin
      @(negedge clk);
      acc = !in_stall;
      if (acc) sb.note_input(item.data, item.is_last);
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic send_list();
    foreach (list_q[i]) send_byte(list_q[i]);
    bytes_sent += list_q.size() - list_junk;
    lists_sent++;
  endtask

  task automatic play_list(input byte_q_t bs);
    list_q.delete();
    foreach (bs[i]) add_byte(bs[i]);
    list_q[list_q.size()-1].is_last = 1'b1;
    list_junk = 0;
    send_list();
  endtask

  task automatic run_lists(int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      gen_list();
      send_list();
    end
  endtask

  // Bytes after a stopping command give no output, so a quiet output does
  // not prove the block idle; allow for its input and plan registers on top.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      if (acc) sb.set_reg(idx, val);
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic configure(logic [7:0] stride, logic [7:0] offset, logic [7:0] base,
                           logic [7:0] fan, logic [7:0] strip);
    drain();
    write_reg(dlvbi_pkg::REG_STRIDE, stride);
    write_reg(dlvbi_pkg::REG_OFFSET, offset);
    write_reg(dlvbi_pkg::REG_BASE, base);
    write_reg(dlvbi_pkg::REG_FAN, fan);
    write_reg(dlvbi_pkg::REG_STRIP, strip);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0] rnd_stride;
    sb            = new();
    bytes_sent    = 0;
    lists_sent    = 0;
    settings_used = 1;
    list_junk     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: fan 0xA0, strip 0x98, stride 1, insertion before the byte.
    // Two vertices, a zero-count strip, a stopping command with ignored bytes.
    play_list('{8'hA0, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h98, 8'h00, 8'h00,
                8'h55, 8'h3C, 8'hC3, 8'h01});
    play_list('{8'hA0, 8'h00});
    play_list('{8'hFF});
    play_list('{8'h98, 8'hFF, 8'hFF, 8'h7E, 8'h81});
    run_lists(12);

    // Opcodes at the extremes; a list cut short just before an insertion.
    configure(8'd4, 8'd2, 8'h80, 8'h00, 8'hFF);
    play_list('{8'h00, 8'h00, 8'h03, 8'h11, 8'h22});
    run_lists(10);

    // Insertion after the last vertex byte, run without any idle cycles.
    no_gaps = 1;
    configure(8'd4, 8'd4, 8'hFF, 8'hA0, 8'h98);
    run_lists(15);
    no_gaps = 0;

    configure(8'd3, 8'd255, 8'h01, 8'hA0, 8'h98);
    run_lists(8);
    configure(8'd1, 8'd1, 8'h7F, 8'hA0, 8'h98);
    run_lists(8);
    // Wide vertices are exercised with lists cut short after a few bytes.
    configure(8'd255, 8'd0, 8'h40, 8'hA0, 8'h98);
    play_list('{8'hA0, 8'h00, 8'h01, 8'h10, 8'h20, 8'h30});
    // A stride of zero stands for 256 bytes per vertex.
    configure(8'd0, 8'd128, 8'h33, 8'hA0, 8'h98);
    play_list('{8'hA0, 8'h00, 8'h02, 8'h5A, 8'h01, 8'h02, 8'h03});

    repeat (2) begin
      rnd_stride = 8'($urandom_range(8, 1));
      configure(rnd_stride, 8'($urandom_range(rnd_stride + 1)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
      run_lists(6);
    end
    drain();

    $display("Run covered %0d lists, %0d list bytes, %0d register settings.",
             lists_sent, bytes_sent, settings_used);
    $display("Output bytes matched: %0d, mismatches: %0d.", sb.matched, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d output bytes still expected.", sb.pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
